### src/rau_pkg.sv
package rau_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int DEN_WIDTH   = FIELD_WIDTH - 1;
   localparam int WIDE_WIDTH  = 2 * FIELD_WIDTH;

   typedef enum logic [2:0] {
      KIND_ADD    = 3'd0,
      KIND_SUB    = 3'd1,
      KIND_MUL    = 3'd2,
      KIND_DIV    = 3'd3,
      KIND_REDUCE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_DIV_ZERO = 2'd1,
      ERR_OVERFLOW = 2'd2
   } err_type;

   // Shared unit: an unsigned restoring divider on WIDE_WIDTH-bit operands.
   typedef struct packed {
      logic                  start;
      logic [WIDE_WIDTH-1:0] dividend;
      logic [WIDE_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [WIDE_WIDTH-1:0] quotient;
      logic [WIDE_WIDTH-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SETUP,
      ST_G1_MUL,
      ST_G1_DIV,
      ST_G1_WAIT,
      ST_L_DIV,
      ST_L_WAIT,
      ST_L_MUL,
      ST_T1_DIV,
      ST_T1_WAIT,
      ST_T1_MUL,
      ST_T2_DIV,
      ST_T2_WAIT,
      ST_T2_MUL,
      ST_COMBINE,
      ST_MUL_LO,
      ST_MUL_DEN,
      ST_G2_DIV,
      ST_G2_WAIT,
      ST_R_NUM,
      ST_R_NUM_WAIT,
      ST_R_DEN,
      ST_R_DEN_WAIT,
      ST_CHECK,
      ST_OUT
   } state_type;

endpackage

### src/rau_divider.sv
module rau_divider
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CW = $clog2(WIDE_WIDTH + 1);

   logic [WIDE_WIDTH-1:0] quo_ff, quo_in;
   logic [WIDE_WIDTH-1:0] rem_ff, rem_in;
   logic [WIDE_WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [WIDE_WIDTH:0]   trial;
   logic [WIDE_WIDTH:0]   diff;

   // One quotient bit per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WIDE_WIDTH-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = CW'(WIDE_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[WIDE_WIDTH]) begin
            rem_in = diff[WIDE_WIDTH-1:0];
            quo_in = {quo_ff[WIDE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDE_WIDTH-1:0];
            quo_in = {quo_ff[WIDE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

### src/rational_arithmetic_unit.sv
// Channel  Direction  Fields (tdata low bit up)
// req      in         tdata: kind[2:0] a_num[34:3] a_den[65:35] b_num[97:66] b_den[128:98]
// rsp      out        tdata: res_num[31:0] res_den[62:32] error[64:63]
// One word at a time. Each GCD step and exact division runs through one
// shared 64-bit restoring divider; the GCD loops take one division per
// Euclid step, so the time per item depends on the operands, and a zero
// denominator or zero divisor goes straight from setup to the result.
// req_tready is high only in idle.
// Synchronous active-high reset returns to idle; a result waiting on a
// low rsp_tready holds its word until taken.
module rational_arithmetic_unit
   import rau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // kind, a_num, a_den, b_num, b_den
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata   // res_num, res_den, error
);

   localparam int W = WIDE_WIDTH;

   state_type state_ff, state_in;
   logic [2:0]   kind_ff;
   logic         sa_ff, sb_ff, neg_ff, neg_in;
   logic [W-1:0] ma_ff, mb_ff, ad_ff, bd_ff;
   // Euclid working pair, lcm, terms and result magnitude/denominator.
   logic [W-1:0] x_ff, x_in, y_ff, y_in;
   logic [W-1:0] l_ff, l_in, t1_ff, t1_in, mag_ff, mag_in, den_ff, den_in;
   logic [1:0]   err_ff, err_in;
   logic [FIELD_WIDTH-1:0] onum_ff, onum_in;
   logic [DEN_WIDTH-1:0]   oden_ff, oden_in;
   logic [W-1:0] mul_a, mul_b, mul_p;
   div_req_type dreq;
   div_rsp_type drsp;

   rau_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Operands stay below 2^32, so one 32x32 multiplier suffices.
   assign mul_p = W'(mul_a[FIELD_WIDTH-1:0]) * W'(mul_b[FIELD_WIDTH-1:0]);

   logic [FIELD_WIDTH-1:0] in_an, in_bn;
   logic [FIELD_WIDTH-1:0] an_mag, bn_mag;
   assign in_an = req_tdata[34:3];
   assign in_bn = req_tdata[97:66];
   // Magnitudes are formed at 32 bits so that -2^31 gives 2^31.
   assign an_mag = in_an[FIELD_WIDTH-1] ? (~in_an + FIELD_WIDTH'(1)) : in_an;
   assign bn_mag = in_bn[FIELD_WIDTH-1] ? (~in_bn + FIELD_WIDTH'(1)) : in_bn;

   logic s2;
   assign s2 = (mb_ff == '0) ? 1'b0 : ((kind_ff == KIND_SUB) ? ~sb_ff : sb_ff);

   localparam logic [W-1:0] LIM = W'(1) << (FIELD_WIDTH - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_SETUP;
         ST_SETUP: begin
            if (kind_ff > KIND_DIV) begin
               state_in = (ad_ff == '0) ? ST_OUT : ST_G2_DIV;
            end else if (ad_ff == '0 || bd_ff == '0) begin
               state_in = ST_OUT;
            end else if (kind_ff <= KIND_SUB) begin
               state_in = ST_G1_DIV;
            end else if (kind_ff == KIND_DIV && mb_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_G1_DIV:  state_in = (y_ff == '0) ? ST_L_DIV : ST_G1_WAIT;
         ST_G1_WAIT: if (drsp.done) state_in = ST_G1_DIV;
         ST_G1_MUL:  state_in = ST_G1_DIV;
         ST_L_DIV:   state_in = ST_L_WAIT;
         ST_L_WAIT:  if (drsp.done) state_in = ST_L_MUL;
         ST_L_MUL:   state_in = ST_T1_DIV;
         ST_T1_DIV:  state_in = ST_T1_WAIT;
         ST_T1_WAIT: if (drsp.done) state_in = ST_T1_MUL;
         ST_T1_MUL:  state_in = ST_T2_DIV;
         ST_T2_DIV:  state_in = ST_T2_WAIT;
         ST_T2_WAIT: if (drsp.done) state_in = ST_T2_MUL;
         ST_T2_MUL:  state_in = ST_COMBINE;
         ST_COMBINE: state_in = ST_G2_DIV;
         ST_MUL_LO:  state_in = ST_MUL_DEN;
         ST_MUL_DEN: state_in = ST_G2_DIV;
         ST_G2_DIV:  state_in = (y_ff == '0) ? ST_R_NUM : ST_G2_WAIT;
         ST_G2_WAIT: if (drsp.done) state_in = ST_G2_DIV;
         ST_R_NUM:   state_in = (x_ff == '0) ? ST_CHECK : ST_R_NUM_WAIT;
         ST_R_NUM_WAIT: if (drsp.done) state_in = ST_R_DEN;
         ST_R_DEN:   state_in = ST_R_DEN_WAIT;
         ST_R_DEN_WAIT: if (drsp.done) state_in = ST_CHECK;
         ST_CHECK:   state_in = ST_OUT;
         ST_OUT:     if (rsp_tready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; l_in = l_ff; t1_in = t1_ff;
      mag_in = mag_ff; den_in = den_ff; neg_in = neg_ff; err_in = err_ff;
      onum_in = onum_ff; oden_in = oden_ff;
      mul_a = '0; mul_b = '0;
      dreq = '0;
      unique case (state_ff)
         ST_SETUP: begin
            err_in = ERR_NONE;
            x_in = ad_ff; y_in = bd_ff;
            mag_in = ma_ff; den_in = ad_ff; neg_in = sa_ff;
            if (kind_ff > KIND_DIV) begin
               if (ad_ff == '0) err_in = ERR_DIV_ZERO;
               x_in = ma_ff; y_in = ad_ff;
            end else if (ad_ff == '0 || bd_ff == '0 ||
                         (kind_ff == KIND_DIV && mb_ff == '0)) begin
               err_in = ERR_DIV_ZERO;
            end
         end
         ST_G1_DIV, ST_G2_DIV: if (y_ff != '0) begin
            dreq.start = 1'b1; dreq.dividend = x_ff; dreq.divisor = y_ff;
         end
         ST_G1_WAIT, ST_G2_WAIT: if (drsp.done) begin
            x_in = y_ff; y_in = drsp.remainder;
         end
         ST_L_DIV: begin
            dreq.start = 1'b1; dreq.dividend = ad_ff; dreq.divisor = x_ff;
         end
         ST_L_WAIT: if (drsp.done) l_in = drsp.quotient;
         ST_L_MUL: begin
            mul_a = l_ff; mul_b = bd_ff; l_in = mul_p;
         end
         ST_T1_DIV: begin
            dreq.start = 1'b1; dreq.dividend = l_ff; dreq.divisor = ad_ff;
         end
         ST_T1_WAIT: if (drsp.done) t1_in = drsp.quotient;
         ST_T1_MUL: begin
            mul_a = ma_ff; mul_b = t1_ff; t1_in = mul_p;
         end
         ST_T2_DIV: begin
            dreq.start = 1'b1; dreq.dividend = l_ff; dreq.divisor = bd_ff;
         end
         ST_T2_WAIT: if (drsp.done) mag_in = drsp.quotient;
         ST_T2_MUL: begin
            mul_a = mb_ff; mul_b = mag_ff; mag_in = mul_p;
         end
         ST_COMBINE: begin
            den_in = l_ff;
            if (sa_ff == s2) begin
               mag_in = t1_ff + mag_ff; neg_in = sa_ff;
            end else if (t1_ff >= mag_ff) begin
               mag_in = t1_ff - mag_ff; neg_in = sa_ff;
            end else begin
               mag_in = mag_ff - t1_ff; neg_in = s2;
            end
            x_in = mag_in; y_in = l_ff;
         end
         ST_MUL_LO: begin
            neg_in = sa_ff ^ sb_ff;
            mul_a = ma_ff;
            mul_b = (kind_ff == KIND_MUL) ? bd_ff : bd_ff;
            if (kind_ff == KIND_MUL) mul_b = mb_ff;
            mag_in = mul_p;
         end
         ST_MUL_DEN: begin
            mul_a = ad_ff;
            mul_b = (kind_ff == KIND_MUL) ? bd_ff : mb_ff;
            den_in = mul_p;
            x_in = mag_ff; y_in = mul_p;
         end
         ST_R_NUM: if (x_ff != '0) begin
            dreq.start = 1'b1; dreq.dividend = mag_ff; dreq.divisor = x_ff;
         end
         ST_R_NUM_WAIT: if (drsp.done) mag_in = drsp.quotient;
         ST_R_DEN: begin
            dreq.start = 1'b1; dreq.dividend = den_ff; dreq.divisor = x_ff;
         end
         ST_R_DEN_WAIT: if (drsp.done) den_in = drsp.quotient;
         ST_CHECK: begin
            if (mag_ff == '0) begin
               neg_in = 1'b0; den_in = W'(1);
            end
            if (err_ff == ERR_NONE) begin
               if (den_in == '0 || den_in > LIM - W'(1) ||
                   (neg_in ? mag_ff > LIM : mag_ff > LIM - W'(1)))
                  err_in = ERR_OVERFLOW;
            end
            onum_in = neg_in ? FIELD_WIDTH'(-mag_ff) : mag_ff[FIELD_WIDTH-1:0];
            oden_in = den_in[DEN_WIDTH-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         kind_ff <= req_tdata[2:0];
         sa_ff   <= in_an[FIELD_WIDTH-1];
         ma_ff   <= W'(an_mag);
         ad_ff   <= W'(req_tdata[65:35]);
         sb_ff   <= in_bn[FIELD_WIDTH-1];
         mb_ff   <= W'(bn_mag);
         bd_ff   <= W'(req_tdata[128:98]);
      end
      x_ff <= x_in; y_ff <= y_in; l_ff <= l_in; t1_ff <= t1_in;
      mag_ff <= mag_in; den_ff <= den_in; neg_ff <= neg_in;
      onum_ff <= onum_in; oden_ff <= oden_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff   <= ERR_NONE;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = (err_ff != ERR_NONE)
      ? {7'd0, err_ff, DEN_WIDTH'(1), FIELD_WIDTH'(0)}
      : {7'd0, err_ff, oden_ff, onum_ff};

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while result pending");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[64:63] != ERR_NONE) |-> rsp_tdata[31:0] == 32'd0)
      else $error("error result not zero");
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[62:32] != 31'd0) else $error("zero denominator");
`endif

endmodule
